FILE: rtl/bfa_pkg.sv
// Package for the bitmap first-free allocator.
// Sizes, field and status codes, request/response structs, controller links.
// No dependencies.
package bfa_pkg;

    localparam int unsigned ENTRIES = 8192;
    localparam int unsigned FIELD_W = 14;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned BIT_W   = $clog2(WORD_W);
    localparam int unsigned ROWS    = ENTRIES / WORD_W;
    localparam int unsigned ROW_W   = $clog2(ROWS);
    localparam int unsigned LIM_MAX = (ENTRIES < 16383) ? ENTRIES : 16383;

    localparam logic [FIELD_W-1:0] USED_MAX    = '1;
    localparam logic [FIELD_W-1:0] TOTAL_RESET = 14'd8192;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_TOTAL = 3'd0;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_MARK  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] entry_number;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] allocated_number;
        logic [1:0]         status;
        logic [FIELD_W-1:0] free_count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic alloc_step;
        logic upd_step;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic is_update;
        logic scan_done;
    } sts_t;

endpackage

FILE: rtl/bfa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bfa_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bfa_datapath.sv
// Allocator datapath: bitmap RAM with row valid bits, scan hint, used counter,
// response register. Depends on bfa_pkg and bfa_ram.
module bfa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfa_pkg::cmd_t                 cmd,
    input  logic [bfa_pkg::FIELD_W-1:0]   total,
    input  bfa_pkg::req_t                 req,
    output bfa_pkg::sts_t                 sts,
    output bfa_pkg::rsp_t                 rsp
);

    localparam int unsigned FW = bfa_pkg::FIELD_W;
    localparam int unsigned WW = bfa_pkg::WORD_W;
    localparam int unsigned BW = bfa_pkg::BIT_W;
    localparam int unsigned RW = bfa_pkg::ROW_W;

    logic [bfa_pkg::ROWS-1:0] valid_reg;
    logic [RW-1:0]            hint_reg;
    logic [FW-1:0]            used_reg;
    logic [RW-1:0]            row_reg;
    logic [1:0]               act_reg;
    logic [BW-1:0]            bit_reg;
    logic [FW-1:0]            got_reg;
    logic [1:0]               stat_reg;
    bfa_pkg::rsp_t            rsp_reg;

    logic [FW-1:0] lim;
    logic [FW-1:0] lim_m1;
    logic          lim_empty;
    logic [RW-1:0] last_row;
    logic [BW-1:0] last_bit;
    logic [FW-1:0] in_m1;
    logic          in_range;
    logic          is_alloc;
    logic          is_update;
    logic [RW-1:0] rd_addr;
    logic [WW-1:0] rd_data;
    logic [WW-1:0] data_word;
    logic [WW-1:0] mask;
    logic [WW-1:0] cand;
    logic          found;
    logic [BW-1:0] low_idx;
    logic [WW-1:0] upd_onehot;
    logic [WW-1:0] wr_data;
    logic          wr_en;
    logic [FW-1:0] free_now;
    logic          upd_was_clear;

    always_comb
    begin
        lim       = (total < FW'(bfa_pkg::LIM_MAX)) ? total : FW'(bfa_pkg::LIM_MAX);
        lim_empty = (lim == '0);
        lim_m1    = lim - FW'(1);
        last_row  = lim_m1[BW +: RW];
        last_bit  = lim_m1[BW-1:0];

        in_m1     = req.entry_number - FW'(1);
        in_range  = (req.entry_number != '0) && (req.entry_number <= lim);
        is_alloc  = (req.action == bfa_pkg::ACT_ALLOC);
        is_update = ((req.action == bfa_pkg::ACT_FREE) || (req.action == bfa_pkg::ACT_MARK))
                    && in_range;

        if (cmd.capture)
        begin
            rd_addr = is_alloc ? hint_reg : in_m1[BW +: RW];
        end
        else
        begin
            rd_addr = row_reg + RW'(1);
        end
    end

    bfa_ram #(
        .WIDTH (WW),
        .DEPTH (bfa_pkg::ROWS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (row_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // rows never written read as all free
    always_comb
    begin
        data_word = valid_reg[row_reg] ? rd_data : '0;

        if (lim_empty || (row_reg > last_row))
        begin
            mask = '0;
        end
        else if (row_reg == last_row)
        begin
            mask = {WW{1'b1}} >> (BW'(WW - 1) - last_bit);
        end
        else
        begin
            mask = '1;
        end

        cand    = ~data_word & mask;
        found   = |cand;
        low_idx = '0;
        for (int i = WW - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                low_idx = BW'(i);
            end
        end

        upd_onehot    = WW'(1) << bit_reg;
        upd_was_clear = ~|(data_word & upd_onehot);

        if (cmd.upd_step)
        begin
            wr_data = (act_reg == bfa_pkg::ACT_FREE) ? (data_word & ~upd_onehot)
                                                      : (data_word | upd_onehot);
        end
        else
        begin
            wr_data = data_word | (WW'(1) << low_idx);
        end
        wr_en = cmd.upd_step || (cmd.alloc_step && found);

        free_now = (used_reg >= lim) ? '0 : (lim - used_reg);

        sts.is_alloc  = is_alloc;
        sts.is_update = is_update;
        sts.scan_done = found || lim_empty || (row_reg >= last_row);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hint_reg  <= '0;
            used_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[row_reg] <= 1'b1;
            end
            if (cmd.alloc_step && found)
            begin
                hint_reg <= row_reg;
                if (used_reg != bfa_pkg::USED_MAX)
                begin
                    used_reg <= used_reg + FW'(1);
                end
            end
            if (cmd.upd_step)
            begin
                if (act_reg == bfa_pkg::ACT_FREE)
                begin
                    if (row_reg < hint_reg)
                    begin
                        hint_reg <= row_reg;
                    end
                    if (used_reg != '0)
                    begin
                        used_reg <= used_reg - FW'(1);
                    end
                end
                else if (upd_was_clear && (used_reg != bfa_pkg::USED_MAX))
                begin
                    used_reg <= used_reg + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= rd_addr;
        if (cmd.capture)
        begin
            act_reg  <= req.action;
            bit_reg  <= in_m1[BW-1:0];
            got_reg  <= '0;
            stat_reg <= (((req.action == bfa_pkg::ACT_FREE) || (req.action == bfa_pkg::ACT_MARK))
                         && !in_range) ? bfa_pkg::ST_RANGE : bfa_pkg::ST_OK;
        end
        if (cmd.alloc_step && sts.scan_done)
        begin
            if (found)
            begin
                got_reg  <= FW'({row_reg, low_idx}) + FW'(1);
                stat_reg <= bfa_pkg::ST_OK;
            end
            else
            begin
                stat_reg <= bfa_pkg::ST_FULL;
            end
        end
        if (cmd.push)
        begin
            rsp_reg.allocated_number <= got_reg;
            rsp_reg.status           <= stat_reg;
            rsp_reg.free_count       <= free_now;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: rtl/bfa_ctrl.sv
// Allocator controller: request sequencing, scan loop control, response valid.
// Depends on bfa_pkg.
module bfa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  bfa_pkg::sts_t sts,
    output bfa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_RESULT
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;

    always_comb
    begin
        cmd.capture    = (state_reg == S_IDLE) && req_valid;
        cmd.alloc_step = (state_reg == S_SCAN);
        cmd.upd_step   = (state_reg == S_UPDATE);
        cmd.push       = (state_reg == S_RESULT) && (!rsp_valid_reg || !rsp_stall);
        req_stall      = (state_reg != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (sts.is_alloc)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else if (sts.is_update)
                        begin
                            state_reg <= S_UPDATE;
                        end
                        else
                        begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_UPDATE:
                begin
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (cmd.push)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: rtl/bitmap_first_free_allocator.sv
// Top level of the bitmap first-free allocator: config register, APB port.
// Depends on bfa_pkg, bfa_ctrl, bfa_datapath.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------
//  req     | in  | req_valid / req_stall  | action, entry_number
//  rsp     | out | rsp_valid / rsp_stall  | allocated_number, status, free_count
//  apb     | in  | psel/penable/pready    | total_entries at address 0
//
// Free and mark in range: update state, then result state. Out-of-range and
// unused actions: result state only. Allocate: scan state reads the 64-bit
// bitmap rows from the scan hint (lowest row that may hold a free bit) up to
// the hit, one row per cycle from the RAM read port; 1 to 128 rows, then result.
// Reset clears row valid bits, so no clearing pass is needed.
// A stalled response holds the block in its result state until taken.
module bitmap_first_free_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  bfa_pkg::req_t                      req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output bfa_pkg::rsp_t                      rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bfa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [bfa_pkg::FIELD_W-1:0] total_entries_reg;
    bfa_pkg::cmd_t               cmd;
    bfa_pkg::sts_t               sts;

    assign pready = 1'b1;
    assign prdata = (paddr == bfa_pkg::ADDR_TOTAL) ? 32'(total_entries_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_entries_reg <= bfa_pkg::TOTAL_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == bfa_pkg::ADDR_TOTAL))
        begin
            total_entries_reg <= pwdata[bfa_pkg::FIELD_W-1:0];
        end
    end

    bfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bfa_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .total (total_entries_reg),
        .req   (req),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

FILE: rtl/bfa_checker.sv
// Port-level checks for the bitmap first-free allocator, bound to the top.
// Depends on bfa_pkg.
module bfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_stall,
    input bfa_pkg::req_t                  req,
    input logic                           rsp_valid,
    input logic                           rsp_stall,
    input bfa_pkg::rsp_t                  rsp,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [bfa_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [31:0]                    pwdata,
    input logic [31:0]                    prdata,
    input logic                           pready
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == bfa_pkg::ST_FULL) |-> (rsp.allocated_number == '0))
        else $error("full status with a number");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == bfa_pkg::ST_RANGE) |-> (rsp.allocated_number == '0))
        else $error("range status with a number");

    a_num_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.allocated_number != '0) |-> (rsp.status == bfa_pkg::ST_OK))
        else $error("allocated number without ok status");

endmodule

bind bitmap_first_free_allocator bfa_checker u_bfa_checker (.*);
